### rtl/hrrn_scheduler_unit_assert.svh
// assertion helpers shared by the scheduler modules
// each check is clocked on clk and held off while rst_n is low
`ifndef HRRN_SCHEDULER_UNIT_ASSERT_SVH
`define HRRN_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define HSU_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("hrrn scheduler check failed");

// next-cycle implication
`define HSU_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("hrrn scheduler check failed");

`endif

### rtl/hrrn_pkg.sv
package hrrn_pkg;

    // field widths
    localparam int ARR_W   = 16;
    localparam int SVC_W   = 12;
    localparam int TIME_W  = 17;
    localparam int NUM_W   = 5;
    localparam int RATIO_W = TIME_W + 1;
    localparam int PROD_W  = RATIO_W + SVC_W;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam int MAX_JOBS_DEF = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_CMP,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_start;
        logic read;
        logic mul;
        logic cmp;
        logic step;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic sched_done;
        logic out_free;
    } status_t;

endpackage

### rtl/hrrn_ram.sv
module hrrn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/hrrn_ctrl.sv
module hrrn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_stall,
    output hrrn_pkg::cmd_t    cmd,
    input  hrrn_pkg::status_t status
);

    import hrrn_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_CMP;
            ST_CMP:
            begin
                state_next = status.scan_last ? ST_EMIT : ST_READ;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.sched_done ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.load       = in_valid;
                cmd.scan_start = in_valid && in_last;
            end
            ST_READ: cmd.read = 1'b1;
            ST_MUL:  cmd.mul = 1'b1;
            ST_CMP:
            begin
                cmd.cmp  = 1'b1;
                cmd.step = !status.scan_last;
            end
            ST_EMIT:
            begin
                cmd.emit       = status.out_free;
                cmd.scan_start = status.out_free && !status.sched_done;
            end
            default: cmd = '0;
        endcase
    end

`include "hrrn_scheduler_unit_assert.svh"

    // a blocked result waits in place
    `HSU_ASSERT_NEXT(a_emit_hold, state_reg == ST_EMIT && !status.out_free, state_reg == ST_EMIT)
    // products are formed only from freshly read job data
    `HSU_ASSERT_IMPL(a_mul_after_read, state_reg == ST_MUL, $past(state_reg) == ST_READ)
    // end of a scan always leads to a decision
    `HSU_ASSERT_NEXT(a_scan_end, state_reg == ST_CMP && status.scan_last, state_reg == ST_EMIT)

endmodule

### rtl/hrrn_dp.sv
module hrrn_dp #(
    parameter int MAX_JOBS = hrrn_pkg::MAX_JOBS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [hrrn_pkg::ARR_W-1:0]   arrival_time,
    input  logic [hrrn_pkg::SVC_W-1:0]   service_time,
    input  hrrn_pkg::cmd_t               cmd,
    output hrrn_pkg::status_t            status,
    output logic [hrrn_pkg::NUM_W-1:0]   job_number,
    output logic [hrrn_pkg::TIME_W-1:0]  start_time,
    output logic [hrrn_pkg::TIME_W-1:0]  finish_time,
    output logic                         last_result,
    output logic                         out_valid,
    input  logic                         out_stall
);

    import hrrn_pkg::*;

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int NUM_X = (IDX_W + 1 > NUM_W) ? IDX_W + 1 : NUM_W;
    localparam int ENT_W = ARR_W + SVC_W;

    // control registers
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    done_reg, done_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [MAX_JOBS-1:0] flags_reg, flags_next;
    logic                found_reg, found_next;
    logic                early_found_reg, early_found_next;
    logic                out_valid_reg, out_valid_next;

    // payload registers
    logic [IDX_W-1:0]   best_idx_reg, early_idx_reg, cand_idx_reg;
    logic [ARR_W-1:0]   best_arr_reg, early_arr_reg, cand_arr_reg;
    logic [SVC_W-1:0]   best_svc_reg, early_svc_reg, cand_svc_reg;
    logic [RATIO_W-1:0] best_r_reg, cand_r_reg;
    logic               cand_elig_reg;
    logic [PROD_W-1:0]  lhs_reg, rhs_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [TIME_W-1:0]  start_reg, finish_reg;
    logic               last_reg;

    // job memory
    logic               store_en;
    logic [SVC_W-1:0]   svc_fixed;
    logic [ENT_W-1:0]   rd_data;
    logic [ARR_W-1:0]   rd_arr;
    logic [SVC_W-1:0]   rd_svc;

    // scan datapath
    logic [TIME_W-1:0]  arr_ext;
    logic               unfinished;
    logic               cand_elig;
    logic [RATIO_W-1:0] cand_r;
    logic [PROD_W-1:0]  lhs_full, rhs_full;
    logic               better;
    logic               early_better;

    // decision datapath
    logic [IDX_W-1:0]   pick_idx;
    logic [SVC_W-1:0]   pick_svc;
    logic [TIME_W-1:0]  pick_start;
    logic [RATIO_W-1:0] fin_sum;
    logic [TIME_W-1:0]  fin_time;
    logic [NUM_X-1:0]   num_ext;

    // store a job when there is room, zero service counts as one
    assign store_en  = cmd.load && (count_reg < CNT_W'(MAX_JOBS));
    assign svc_fixed = (service_time == '0) ? SVC_W'(1) : service_time;

    hrrn_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_JOBS),
        .AW    (IDX_W)
    ) u_job_ram (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data ({arrival_time, svc_fixed}),
        .rd_en   (cmd.read),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign rd_arr = rd_data[ENT_W-1:SVC_W];
    assign rd_svc = rd_data[SVC_W-1:0];

    // candidate ratio terms, cross products against the current best
    assign arr_ext    = {1'b0, rd_arr};
    assign unfinished = !flags_reg[idx_reg];
    assign cand_elig  = unfinished && (arr_ext <= time_reg);
    assign cand_r     = RATIO_W'(time_reg - arr_ext) + RATIO_W'(rd_svc);
    assign lhs_full   = cand_r * best_svc_reg;
    assign rhs_full   = best_r_reg * rd_svc;
    assign early_better = unfinished && (!early_found_reg || (rd_arr < early_arr_reg));

    // ratio compare, ties to the earlier arrival, then the lower number
    assign better = !found_reg || (lhs_reg > rhs_reg)
                    || ((lhs_reg == rhs_reg) && (cand_arr_reg < best_arr_reg));

    // with nothing arrived, time jumps to the earliest pending job
    assign pick_idx   = found_reg ? best_idx_reg : early_idx_reg;
    assign pick_svc   = found_reg ? best_svc_reg : early_svc_reg;
    assign pick_start = found_reg ? time_reg : {1'b0, early_arr_reg};
    assign fin_sum    = RATIO_W'(pick_start) + RATIO_W'(pick_svc);
    assign fin_time   = (fin_sum > RATIO_W'(TIME_MAX)) ? TIME_MAX : fin_sum[TIME_W-1:0];
    assign num_ext    = NUM_X'(pick_idx) + NUM_X'(1);

    // status to the controller
    assign status.scan_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign status.sched_done = (done_reg + CNT_W'(1)) == count_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

    // control next values
    always_comb
    begin
        count_next       = count_reg;
        done_next        = done_reg;
        idx_next         = idx_reg;
        time_next        = time_reg;
        flags_next       = flags_reg;
        found_next       = found_reg;
        early_found_next = early_found_reg;
        out_valid_next   = out_valid_reg;

        if (store_en)
        begin
            count_next = count_reg + CNT_W'(1);
            flags_next[count_reg[IDX_W-1:0]] = 1'b0;
        end
        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.mul && early_better)
        begin
            early_found_next = 1'b1;
        end
        if (cmd.cmp && cand_elig_reg && better)
        begin
            found_next = 1'b1;
        end
        if (cmd.step)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (status.sched_done)
            begin
                count_next = '0;
                done_next  = '0;
                time_next  = '0;
                flags_next = '0;
            end
            else
            begin
                done_next  = done_reg + CNT_W'(1);
                time_next  = fin_time;
                flags_next[pick_idx] = 1'b1;
            end
        end
        if (cmd.scan_start)
        begin
            idx_next         = '0;
            found_next       = 1'b0;
            early_found_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            done_reg        <= '0;
            idx_reg         <= '0;
            time_reg        <= '0;
            flags_reg       <= '0;
            found_reg       <= 1'b0;
            early_found_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            done_reg        <= done_next;
            idx_reg         <= idx_next;
            time_reg        <= time_next;
            flags_reg       <= flags_next;
            found_reg       <= found_next;
            early_found_reg <= early_found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // candidate, earliest, best and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            cand_idx_reg  <= idx_reg;
            cand_arr_reg  <= rd_arr;
            cand_svc_reg  <= rd_svc;
            cand_r_reg    <= cand_r;
            cand_elig_reg <= cand_elig;
            lhs_reg       <= lhs_full;
            rhs_reg       <= rhs_full;
            if (early_better)
            begin
                early_idx_reg <= idx_reg;
                early_arr_reg <= rd_arr;
                early_svc_reg <= rd_svc;
            end
        end
        if (cmd.cmp && cand_elig_reg && better)
        begin
            best_idx_reg <= cand_idx_reg;
            best_arr_reg <= cand_arr_reg;
            best_svc_reg <= cand_svc_reg;
            best_r_reg   <= cand_r_reg;
        end
        if (cmd.emit)
        begin
            num_reg    <= num_ext[NUM_W-1:0];
            start_reg  <= pick_start;
            finish_reg <= fin_time;
            last_reg   <= status.sched_done;
        end
    end

    assign job_number  = num_reg;
    assign start_time  = start_reg;
    assign finish_time = finish_reg;
    assign last_result = last_reg;
    assign out_valid   = out_valid_reg;

`include "hrrn_scheduler_unit_assert.svh"

    // a new result never overwrites one still waiting
    `HSU_ASSERT_IMPL(a_emit_room, cmd.emit, !out_valid_reg || !out_stall)
    // stored job count stays within the memory
    `HSU_ASSERT_IMPL(a_count_max, 1'b1, count_reg <= CNT_W'(MAX_JOBS))
    // the final result leaves a fresh job set behind
    `HSU_ASSERT_NEXT(a_set_clear, cmd.emit && status.sched_done, count_reg == '0 && time_reg == '0 && flags_reg == '0)

endmodule

### rtl/hrrn_scheduler_unit.sv
// Highest-response-ratio-next job scheduler. Jobs are loaded one item per cycle, while
// in_stall is low, as (arrival_time, service_time) and numbered from 1 in input order;
// the item with last_item set closes the set and starts a non-preemptive schedule from
// tick 0, after which one result item per job leaves in run order with its number, start
// and finish tick, the final one marked last_result. Each decision walks all N stored jobs
// through the job memory, one read, one cross-multiply and one compare per job. in_stall
// stays high from the last job until the final result has been placed in the output
// register. Up to MAX_JOBS jobs are kept; further jobs of the same set are dropped.
// Times saturate at 131071.
module hrrn_scheduler_unit #(
    parameter int MAX_JOBS = hrrn_pkg::MAX_JOBS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [hrrn_pkg::ARR_W-1:0]   arrival_time,
    input  logic [hrrn_pkg::SVC_W-1:0]   service_time,
    input  logic                         last_item,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [hrrn_pkg::NUM_W-1:0]   job_number,
    output logic [hrrn_pkg::TIME_W-1:0]  start_time,
    output logic [hrrn_pkg::TIME_W-1:0]  finish_time,
    output logic                         last_result
);

    import hrrn_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    hrrn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last_item),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    // job store, ratio compare and result register
    hrrn_dp #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .arrival_time (arrival_time),
        .service_time (service_time),
        .cmd          (cmd),
        .status       (status),
        .job_number   (job_number),
        .start_time   (start_time),
        .finish_time  (finish_time),
        .last_result  (last_result),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

endmodule

### verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hrrn_pkg::*;

    localparam int JOBS         = MAX_JOBS_DEF;
    localparam int RUN_LIMIT    = 2000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;

    // arrival patterns for random job sets
    typedef enum int {
        PAT_CLUSTER,
        PAT_SPREAD,
        PAT_WIDE,
        PAT_EDGE
    } pattern_t;

    // one expected run of a job
    typedef struct {
        bit [NUM_W-1:0]  num;
        bit [TIME_W-1:0] start;
        bit [TIME_W-1:0] fin;
        bit              last;
    } job_run_t;

    class schedule_board;
        bit [ARR_W-1:0] arr_q [JOBS];
        bit [SVC_W-1:0] svc_q [JOBS];
        bit             ran [JOBS];
        int             njobs;
        int             errors;
        job_run_t       pending_runs [$];

        function new();
            njobs  = 0;
            errors = 0;
        endfunction

        // exact ratio compare, tie goes to earlier arrival
        function bit prefers(int x, int y, longint now);
            longint rx;
            longint ry;
            longint lhs;
            longint rhs;
            rx  = now - longint'(arr_q[x]) + longint'(svc_q[x]);
            ry  = now - longint'(arr_q[y]) + longint'(svc_q[y]);
            lhs = rx * longint'(svc_q[y]);
            rhs = ry * longint'(svc_q[x]);
            if (lhs != rhs)
                return lhs > rhs;
            return arr_q[x] < arr_q[y];
        endfunction

        // run the whole set and queue one run per job
        function void plan_schedule();
            longint   now;
            longint   earliest;
            longint   fin;
            int       pick;
            bit       found;
            job_run_t r;
            now = 0;
            for (int d = 0; d < njobs; d++)
            begin
                earliest = 64'h7fff_ffff_ffff_ffff;
                for (int i = 0; i < njobs; i++)
                begin
                    if (!ran[i] && longint'(arr_q[i]) < earliest)
                        earliest = longint'(arr_q[i]);
                end
                // idle until the next arrival
                if (earliest > now)
                    now = earliest;
                found = 1'b0;
                pick  = 0;
                for (int i = 0; i < njobs; i++)
                begin
                    if (!ran[i] && longint'(arr_q[i]) <= now)
                    begin
                        if (!found || prefers(i, pick, now))
                        begin
                            pick  = i;
                            found = 1'b1;
                        end
                    end
                end
                fin = now + longint'(svc_q[pick]);
                if (fin > longint'(TIME_MAX))
                    fin = longint'(TIME_MAX);
                ran[pick] = 1'b1;
                r.num   = NUM_W'(pick + 1);
                r.start = TIME_W'(now);
                r.fin   = TIME_W'(fin);
                r.last  = (d == njobs - 1);
                pending_runs.push_back(r);
                now = fin;
            end
            njobs = 0;
            for (int i = 0; i < JOBS; i++)
                ran[i] = 1'b0;
        endfunction

        function void note_job(bit [ARR_W-1:0] arr, bit [SVC_W-1:0] svc, bit last);
            // zero service counts as one tick
            if (svc == '0)
                svc = SVC_W'(1);
            // jobs past a full store are dropped
            if (njobs < JOBS)
            begin
                arr_q[njobs] = arr;
                svc_q[njobs] = svc;
                ran[njobs]   = 1'b0;
                njobs++;
            end
            if (last)
                plan_schedule();
        endfunction

        function void check_result(logic [NUM_W-1:0] num, logic [TIME_W-1:0] start,
                                   logic [TIME_W-1:0] fin, logic last);
            job_run_t r;
            if (pending_runs.size() == 0)
            begin
                $error("result with nothing expected: job_number %0d", num);
                errors++;
                return;
            end
            r = pending_runs.pop_front();
            if (num !== r.num)
            begin
                $error("job_number: expected %0d, actual %0d", r.num, num);
                errors++;
            end
            if (start !== r.start)
            begin
                $error("start_time: expected %0d, actual %0d", r.start, start);
                errors++;
            end
            if (fin !== r.fin)
            begin
                $error("finish_time: expected %0d, actual %0d", r.fin, fin);
                errors++;
            end
            if (last !== r.last)
            begin
                $error("last_result: expected %0d, actual %0d", r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [ARR_W-1:0]   arrival_time = '0;
    logic [SVC_W-1:0]   service_time = '0;
    logic               last_item    = 1'b0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [NUM_W-1:0]   job_number;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  finish_time;
    logic               last_result;

    schedule_board board = new();

    int idle_pct  = 26;
    int stall_pct = 64;
    int sent      = 0;
    bit hold_req  = 1'b0;

    hrrn_scheduler_unit #(
        .MAX_JOBS(JOBS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .arrival_time (arrival_time),
        .service_time (service_time),
        .last_item    (last_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .job_number   (job_number),
        .start_time   (start_time),
        .finish_time  (finish_time),
        .last_result  (last_result)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one job item and wait until it is taken
    task automatic offer_job(input bit [ARR_W-1:0] arr, input bit [SVC_W-1:0] svc,
                             input bit last);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        arrival_time <= arr;
        service_time <= svc;
        last_item    <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_job(arr, svc, last);
        sent++;
    endtask

    // one job set of random size and arrival pattern
    task automatic send_random_set();
        int             size;
        int             roll;
        int             base;
        pattern_t       shape;
        bit [ARR_W-1:0] arr;
        bit [SVC_W-1:0] svc;
        roll = $urandom_range(99);
        if (roll < 60)
            size = $urandom_range(1, 5);
        else if (roll < 92)
            size = $urandom_range(6, JOBS);
        else
            size = $urandom_range(JOBS + 1, JOBS + 3);
        shape = pattern_t'($urandom_range(3));
        base  = $urandom_range(0, 60000);
        for (int k = 0; k < size; k++)
        begin
            case (shape)
                PAT_CLUSTER:
                begin
                    arr = ARR_W'(base + $urandom_range(0, 20));
                    svc = SVC_W'($urandom_range(1, 8));
                end
                PAT_SPREAD:
                begin
                    arr = ARR_W'(base + $urandom_range(0, 2000));
                    svc = SVC_W'($urandom_range(1, 300));
                end
                PAT_WIDE:
                begin
                    arr = ARR_W'($urandom);
                    svc = SVC_W'($urandom);
                end
                default:
                begin
                    arr = $urandom_range(1) ? '1 : '0;
                    roll = $urandom_range(2);
                    svc = (roll == 0) ? 12'd1 : (roll == 1) ? '1 : 12'($urandom);
                end
            endcase
            offer_job(arr, svc, k == size - 1);
        end
    endtask

    // receiver side, with one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_result(job_number, start_time, finish_time, last_result);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // run limit
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // stimulus
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // single job at the smallest fields
        offer_job(16'd0, 12'd1, 1'b1);
        // single job at the largest fields
        offer_job('1, '1, 1'b1);
        // equal ratios and equal arrivals, lower number wins
        offer_job(16'd0, 12'd4, 1'b0);
        offer_job(16'd2, 12'd2, 1'b0);
        offer_job(16'd2, 12'd2, 1'b1);
        // zero service times and idle gaps before arrivals
        offer_job(16'd3, 12'd0, 1'b0);
        offer_job(16'd3, 12'd0, 1'b0);
        offer_job(16'd40, 12'd5, 1'b1);
        // full store, the closing job is dropped
        for (int k = 0; k < JOBS + 1; k++)
            offer_job(ARR_W'(16'hffff - k), SVC_W'(12'hfff - k), k == JOBS);

        // sender idles less than the receiver
        while (sent < 170)
            send_random_set();
        // receiver stalls less than the sender idles
        idle_pct  = 64;
        stall_pct = 26;
        while (sent < 320)
            send_random_set();
        // no idling, with one long receiver hold-off
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        while (sent < 462)
            send_random_set();
        in_valid <= 1'b0;

        // drain
        while (board.pending_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending_runs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/hrrn_pkg.sv
rtl/hrrn_ram.sv
rtl/hrrn_ctrl.sv
rtl/hrrn_dp.sv
rtl/hrrn_scheduler_unit.sv
verif/tb_top.sv
